// File: rtl/slfp_pkg.sv
// Shared types, codes and reset constants for the sync/length/Fletcher frame parser.
`timescale 1ns / 1ps
`default_nettype none

package slfp_pkg;

    // Register indexes on the configuration port.
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SYNC_FIRST  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SYNC_SECOND = 1'b1;

    // Reset values of the sync bytes: ASCII 'A' and 'q'.
    localparam logic [7:0] SYNC_FIRST_RST  = 8'd65;
    localparam logic [7:0] SYNC_SECOND_RST = 8'd113;

    // Parser phases.
    typedef enum logic [2:0] {
        PH_SYNC1 = 3'd0,
        PH_SYNC2 = 3'd1,
        PH_LEN   = 3'd2,
        PH_DATA  = 3'd3,
        PH_CHKA  = 3'd4,
        PH_CHKB  = 3'd5
    } phase_t;

    // Result event codes.
    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_PAYLOAD = 3'd1,
        EV_ACCEPT  = 3'd2,
        EV_BAD_A   = 3'd3,
        EV_BAD_B   = 3'd4
    } event_t;

    // Configured sync pattern, passed from the register file to the parser.
    typedef struct packed {
        logic [7:0] sync_first;
        logic [7:0] sync_second;
    } cfg_t;

endpackage

`default_nettype wire

// File: rtl/slfp_cfg_regs.sv
// Configuration register file holding the two sync byte values.
`timescale 1ns / 1ps
`default_nettype none

module slfp_cfg_regs
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [slfp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]                    cfg_data,
    output slfp_pkg::cfg_t                     cfg
);
    import slfp_pkg::*;

    logic [7:0] sync_first_reg;
    logic [7:0] sync_second_reg;

    // Register writes, decoded by index.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg  <= SYNC_FIRST_RST;
            sync_second_reg <= SYNC_SECOND_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_IDX_SYNC_FIRST:  sync_first_reg  <= cfg_data;
                CFG_IDX_SYNC_SECOND: sync_second_reg <= cfg_data;
                default:             sync_first_reg  <= sync_first_reg;
            endcase
        end
    end

    assign cfg.sync_first  = sync_first_reg;
    assign cfg.sync_second = sync_second_reg;

endmodule

`default_nettype wire

// File: rtl/slfp_parse_core.sv
// Frame parser state machine, Fletcher sums and the registered result stage.
`timescale 1ns / 1ps
`default_nettype none

module slfp_parse_core
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  slfp_pkg::cfg_t      cfg,
    input  wire logic           item_valid,
    input  wire logic [7:0]     item_byte,
    output logic                item_ready,
    output logic                out_valid,
    input  wire logic           out_ready,
    output slfp_pkg::event_t    out_event,
    output logic [7:0]          out_byte,
    output logic [7:0]          out_index,
    output logic                out_last
);
    import slfp_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [7:0] sum_a_reg, sum_a_next;
    logic [7:0] sum_b_reg, sum_b_next;
    logic [7:0] len_reg, len_next;
    logic [7:0] taken_reg, taken_next;

    logic       out_vld_reg, out_vld_next;
    event_t     ev_reg, ev_next;
    logic [7:0] pbyte_reg, pbyte_next;
    logic [7:0] pidx_reg, pidx_next;
    logic       plast_reg, plast_next;

    logic       advance;
    logic       step;
    logic [7:0] add_a;
    logic [7:0] add_b;

    // The result register moves whenever it is empty or being drained.
    assign advance    = !out_vld_reg || out_ready;
    assign item_ready = advance;
    assign step       = advance && item_valid;

    // Running Fletcher sums with the current byte folded in.
    assign add_a = sum_a_reg + item_byte;
    assign add_b = sum_b_reg + add_a;

    // Next phase, sums and result for the item at the head of the pipe.
    always_comb
    begin
        phase_next = phase_reg;
        sum_a_next = sum_a_reg;
        sum_b_next = sum_b_reg;
        len_next   = len_reg;
        taken_next = taken_reg;
        ev_next    = EV_NONE;
        pbyte_next = 8'd0;
        pidx_next  = 8'd0;
        plast_next = 1'b0;

        unique case (phase_reg)
            PH_SYNC1:
            begin
                if (item_byte == cfg.sync_first)
                begin
                    phase_next = PH_SYNC2;
                end
            end
            PH_SYNC2:
            begin
                if (item_byte == cfg.sync_second)
                begin
                    sum_a_next = 8'd0;
                    sum_b_next = 8'd0;
                    phase_next = PH_LEN;
                end
                else
                begin
                    phase_next = PH_SYNC1;
                end
            end
            PH_LEN:
            begin
                sum_a_next = add_a;
                sum_b_next = add_b;
                len_next   = item_byte;
                taken_next = 8'd0;
                phase_next = PH_DATA;
            end
            PH_DATA:
            begin
                sum_a_next = add_a;
                sum_b_next = add_b;
                ev_next    = EV_PAYLOAD;
                pbyte_next = item_byte;
                pidx_next  = taken_reg;
                taken_next = taken_reg + 8'd1;
                // A length of zero wraps the count and means 256 bytes.
                if (taken_next == len_reg)
                begin
                    plast_next = 1'b1;
                    phase_next = PH_CHKA;
                end
            end
            PH_CHKA:
            begin
                if (item_byte != sum_a_reg)
                begin
                    ev_next    = EV_BAD_A;
                    phase_next = PH_SYNC1;
                end
                else
                begin
                    phase_next = PH_CHKB;
                end
            end
            PH_CHKB:
            begin
                ev_next    = (item_byte == sum_b_reg) ? EV_ACCEPT : EV_BAD_B;
                phase_next = PH_SYNC1;
            end
            default:
            begin
                phase_next = PH_SYNC1;
            end
        endcase
    end

    // Valid flag of the result register.
    always_comb
    begin
        out_vld_next = advance ? item_valid : out_vld_reg;
    end

    // Parser state and result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_SYNC1;
            sum_a_reg   <= 8'd0;
            sum_b_reg   <= 8'd0;
            len_reg     <= 8'd0;
            taken_reg   <= 8'd0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
            if (step)
            begin
                phase_reg <= phase_next;
                sum_a_reg <= sum_a_next;
                sum_b_reg <= sum_b_next;
                len_reg   <= len_next;
                taken_reg <= taken_next;
            end
        end
    end

    // Result payload, loaded with each processed item.
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            ev_reg    <= ev_next;
            pbyte_reg <= pbyte_next;
            pidx_reg  <= pidx_next;
            plast_reg <= plast_next;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_event = ev_reg;
    assign out_byte  = pbyte_reg;
    assign out_index = pidx_reg;
    assign out_last  = plast_reg;

endmodule

`default_nettype wire

// File: rtl/sync_length_fletcher_frame_parser.sv
// An accepted byte passes through the input register and then the result register.
// The parser takes one byte per clock; the result register stalls only on out_ready low.
// Every accepted byte produces exactly one result item, event 0 when nothing happens.
// Reset (rst_n low, asynchronous) empties both registers, restores the sync bytes
// to 'A' and 'q', clears the sums and counters, and returns the parser to hunting.
`timescale 1ns / 1ps
`default_nettype none

module sync_length_fletcher_frame_parser
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [slfp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]                     cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [7:0]                     rx_byte,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [2:0]                          event_res,
    output logic [7:0]                          payload_byte,
    output logic [7:0]                          payload_index,
    output logic                                last_payload
);
    import slfp_pkg::*;

    cfg_t       cfg;
    logic       in_vld_reg, in_vld_next;
    logic [7:0] in_byte_reg;
    logic       item_ready;
    event_t     out_event;

    // Configuration registers.
    slfp_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Input register: refilled whenever it is empty or its item moves on.
    assign in_ready = !in_vld_reg || item_ready;

    always_comb
    begin
        in_vld_next = in_ready ? in_valid : in_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    // Parser and result register.
    slfp_parse_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (in_vld_reg),
        .item_byte  (in_byte_reg),
        .item_ready (item_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_event  (out_event),
        .out_byte   (payload_byte),
        .out_index  (payload_index),
        .out_last   (last_payload)
    );

    assign event_res = out_event;

`ifndef SYNTHESIS
    // Fields other than the event are zero unless the item carries a payload byte.
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_event != EV_PAYLOAD)) |->
            (payload_byte == 8'd0 && payload_index == 8'd0 && !last_payload))
        else $error("non-payload result carries payload fields");

    // The input side stalls only while it holds an item the parser cannot take.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (in_vld_reg && out_valid && !out_ready))
        else $error("input stalled without a blocked result");

    // A result appears only for an item that sat in the input register.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_vld_reg))
        else $error("result raised without a buffered item");
`endif

endmodule

`default_nettype wire
